// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL datapath of the dual queue block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/dqsb_pkg.sv =====
// Shared types and constants of the dual queue shared buffer.
package dqsb_pkg;

  localparam int DefaultDepth = 16;

  // Operation codes carried in the input tuser.
  localparam logic [1:0] OpInsA = 2'd0;
  localparam logic [1:0] OpInsB = 2'd1;
  localparam logic [1:0] OpRemA = 2'd2;
  localparam logic [1:0] OpRemB = 2'd3;

  // Status codes carried in the output tuser.
  localparam logic [1:0] StsOk        = 2'd0;
  localparam logic [1:0] StsOverflow  = 2'd1;
  localparam logic [1:0] StsUnderflow = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;  // capture the input transfer
    logic exec;  // perform the operation
    logic emit;  // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== hdl/dqsb_ctrl.sv =====
// Controller state machine of the dual queue shared buffer.
module dqsb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dqsb_pkg::dp_stat_t stat_i,
  output dqsb_pkg::dp_cmd_t  cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/dqsb_dp.sv =====
// Datapath of the dual queue shared buffer: pointers, storage and output register.
`include "assert_macros.svh"
module dqsb_dp #(
  parameter int DEPTH = dqsb_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dqsb_pkg::dp_cmd_t  cmd_i,
  output dqsb_pkg::dp_stat_t stat_o,
  input  logic [1:0]         op_i,
  input  logic [31:0]        value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        read_value_o
);

  localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PtrW = IdxW + 1;
  localparam logic [PtrW-1:0] DepthP = PtrW'(DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

  logic [31:0]     mem [DEPTH];
  logic [31:0]     mem_rd_q;

  logic [1:0]      op_q;
  logic [31:0]     value_q;

  logic [IdxW-1:0] head_a_q, head_a_d, tail_a_q, tail_a_d;
  logic [IdxW-1:0] head_b_q, head_b_d, tail_b_q, tail_b_d;
  logic            empty_a_q, empty_a_d, empty_b_q, empty_b_d;

  logic [1:0]      res_sts_q, res_sts_d;
  logic            res_rd_q, res_rd_d;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [IdxW-1:0] rd_addr;

  logic            out_valid_q;
  logic [1:0]      out_sts_q;
  logic [31:0]     out_data_q;

  always_comb begin
    logic [PtrW-1:0] limit_a;
    logic [PtrW-1:0] next_a;
    logic [PtrW-1:0] next_b;
    logic            full_b;
    head_a_d  = head_a_q;
    tail_a_d  = tail_a_q;
    empty_a_d = empty_a_q;
    head_b_d  = head_b_q;
    tail_b_d  = tail_b_q;
    empty_b_d = empty_b_q;
    res_sts_d = dqsb_pkg::StsOk;
    res_rd_d  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    rd_addr   = (op_q == dqsb_pkg::OpRemA) ? head_a_q : head_b_q;

    // A may grow up to the slot just below B's newest slot.
    limit_a = empty_b_q ? DepthP : {1'b0, tail_b_q};
    next_a  = empty_a_q ? '0 : ({1'b0, tail_a_q} + PtrW'(1));
    if (empty_b_q) begin
      next_b = {1'b0, LastIdx};
      full_b = !empty_a_q && (tail_a_q >= LastIdx);
    end else begin
      full_b = (tail_b_q == '0);
      next_b = full_b ? '0 : ({1'b0, tail_b_q} - PtrW'(1));
      if (!full_b && !empty_a_q && ({1'b0, tail_a_q} >= next_b)) begin
        full_b = 1'b1;
      end
    end

    case (op_q)
      dqsb_pkg::OpInsA: begin
        if (next_a >= limit_a) begin
          res_sts_d = dqsb_pkg::StsOverflow;
        end else begin
          if (empty_a_q) begin
            head_a_d = '0;
          end
          empty_a_d = 1'b0;
          tail_a_d  = next_a[IdxW-1:0];
          wr_en     = 1'b1;
          wr_addr   = next_a[IdxW-1:0];
        end
      end
      dqsb_pkg::OpInsB: begin
        if (full_b) begin
          res_sts_d = dqsb_pkg::StsOverflow;
        end else begin
          if (empty_b_q) begin
            head_b_d = LastIdx;
          end
          empty_b_d = 1'b0;
          tail_b_d  = next_b[IdxW-1:0];
          wr_en     = 1'b1;
          wr_addr   = next_b[IdxW-1:0];
        end
      end
      dqsb_pkg::OpRemA: begin
        if (empty_a_q) begin
          res_sts_d = dqsb_pkg::StsUnderflow;
        end else begin
          res_rd_d = 1'b1;
          if (head_a_q >= tail_a_q) begin
            head_a_d  = '0;
            tail_a_d  = '0;
            empty_a_d = 1'b1;
          end else begin
            head_a_d = head_a_q + IdxW'(1);
          end
        end
      end
      default: begin
        if (empty_b_q) begin
          res_sts_d = dqsb_pkg::StsUnderflow;
        end else begin
          res_rd_d = 1'b1;
          if (head_b_q <= tail_b_q) begin
            head_b_d  = LastIdx;
            tail_b_d  = LastIdx;
            empty_b_d = 1'b1;
          end else begin
            head_b_d = head_b_q - IdxW'(1);
          end
        end
      end
    endcase
  end

  // Queue pointers and flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_a_q  <= '0;
      tail_a_q  <= '0;
      empty_a_q <= 1'b1;
      head_b_q  <= LastIdx;
      tail_b_q  <= LastIdx;
      empty_b_q <= 1'b1;
    end else if (cmd_i.exec) begin
      head_a_q  <= head_a_d;
      tail_a_q  <= tail_a_d;
      empty_a_q <= empty_a_d;
      head_b_q  <= head_b_d;
      tail_b_q  <= tail_b_d;
      empty_b_q <= empty_b_d;
    end
  end

  // Storage array, at most one write and one registered read per operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (wr_en) begin
        mem[wr_addr] <= value_q;
      end
      mem_rd_q <= mem[rd_addr];
    end
  end

  // Captured item and pending result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q    <= op_i;
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      res_sts_q <= res_sts_d;
      res_rd_q  <= res_rd_d;
    end
    if (cmd_i.emit) begin
      out_sts_q  <= res_sts_q;
      out_data_q <= res_rd_q ? mem_rd_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_sts_q;
  assign read_value_o    = out_data_q;

  `ASSERT_IMPL(a_empty_a_home, clk_i, rst_ni, empty_a_q, (head_a_q == '0) && (tail_a_q == '0))
  `ASSERT_IMPL(a_empty_b_home, clk_i, rst_ni, empty_b_q, (head_b_q == LastIdx) && (tail_b_q == LastIdx))
  `ASSERT_IMPL(a_no_cross, clk_i, rst_ni, !empty_a_q && !empty_b_q, tail_a_q < tail_b_q)
  `ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd_i.emit, out_valid_q)

endmodule

// ===== hdl/dual_queue_shared_buffer.sv =====
// Top level of the dual queue shared buffer: two FIFO queues in one storage array.
//
// Channel  Dir  tdata                 tuser
// s_axis   in   [31:0] value          [1:0] op (insert A/B, remove A/B)
// m_axis   out  [31:0] read_value     [1:0] status (ok, overflow, underflow)
//
// Each transfer runs in three steps: capture, execute (pointer update, storage
// write and registered storage read at the queue head), and load of the output
// register. The storage array's single registered read port sets that order.
// The next item is accepted while a result still waits in the output register;
// a stalled output holds the following result in the datapath until it drains.
// Reset empties both queues; storage contents are not cleared and need no pass.
module dual_queue_shared_buffer #(
  parameter int DEPTH = dqsb_pkg::DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] read_value
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  dqsb_pkg::dp_cmd_t  cmd;
  dqsb_pkg::dp_stat_t stat;

  // Sequence capture, execute and emit for one transfer at a time.
  dqsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold queue pointers, storage and the output register.
  dqsb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (s_axis_tuser_i),
    .value_i      (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .status_o     (m_axis_tuser_o),
    .read_value_o (m_axis_tdata_o)
  );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the dual queue shared buffer under directed and random traffic.
module testbench;

  localparam int unsigned Depth = dqsb_pkg::DefaultDepth;
  localparam int NumItems = 1900;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 20;
  localparam int ResetCycles = 11;
  localparam int ReportLimit = 10;
  localparam logic [31:0] FillWords [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                            32'hAAAA_AAAA, 32'h5555_5555};
  localparam logic [31:0] EdgeWords [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                            32'h8000_0000, 32'h7FFF_FFFF};

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word;
  } result_t;

  // Traffic mixes for the random part; fill runs reach the overflow points, drain runs the underflow points.
  typedef enum int {MixAll, FillA, FillB, FillBoth, DrainBoth} traffic_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // [31:0] value
  logic [1:0]  s_axis_tuser_i;   // [1:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;   // [31:0] read_value
  logic [1:0]  m_axis_tuser_o;   // [1:0] status

  int items_sent = 0;

  dual_queue_shared_buffer u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mirror of the two queues plus the list of results still owed by the block.
  class QueuePairScoreboard;
    logic [31:0] slots [Depth];
    int unsigned a_head, a_tail, b_head, b_tail;
    bit          a_empty, b_empty;
    result_t     owed [$];
    int          failures, checked, overflows, underflows;
    int          op_count [4];

    function new();
      foreach (slots[i]) slots[i] = '0;
      a_head = 0;
      a_tail = 0;
      a_empty = 1'b1;
      b_head = Depth - 1;
      b_tail = Depth - 1;
      b_empty = 1'b1;
      failures = 0;
      checked = 0;
      overflows = 0;
      underflows = 0;
      foreach (op_count[i]) op_count[i] = 0;
    endfunction

    // Apply one accepted operation to the mirror and queue its result.
    function void note_request(logic [1:0] op, logic [31:0] value);
      result_t     r;
      int unsigned limit, nxt;
      bit          full;
      r.status = dqsb_pkg::StsOk;
      r.word = '0;
      case (op)
        dqsb_pkg::OpInsA: begin
          // A may grow up to the slot just below B's newest entry.
          limit = b_empty ? Depth : b_tail;
          nxt = a_empty ? 0 : a_tail + 1;
          if (nxt >= limit) begin
            r.status = dqsb_pkg::StsOverflow;
          end else begin
            if (a_empty) begin
              a_head = 0;
              a_empty = 1'b0;
            end
            a_tail = nxt;
            slots[nxt] = value;
          end
        end
        dqsb_pkg::OpInsB: begin
          if (b_empty) begin
            nxt = Depth - 1;
            full = !a_empty && a_tail >= nxt;
          end else begin
            full = (b_tail == 0);
            nxt = full ? 0 : b_tail - 1;
            if (!full && !a_empty && a_tail >= nxt) full = 1'b1;
          end
          if (full) begin
            r.status = dqsb_pkg::StsOverflow;
          end else begin
            if (b_empty) begin
              b_head = Depth - 1;
              b_empty = 1'b0;
            end
            b_tail = nxt;
            slots[nxt] = value;
          end
        end
        dqsb_pkg::OpRemA: begin
          if (a_empty) begin
            r.status = dqsb_pkg::StsUnderflow;
          end else begin
            r.word = slots[a_head];
            // Taking the last entry rewinds A to slot 0.
            if (a_head >= a_tail) begin
              a_head = 0;
              a_tail = 0;
              a_empty = 1'b1;
            end else begin
              a_head++;
            end
          end
        end
        default: begin
          if (b_empty) begin
            r.status = dqsb_pkg::StsUnderflow;
          end else begin
            r.word = slots[b_head];
            if (b_head <= b_tail) begin
              b_head = Depth - 1;
              b_tail = Depth - 1;
              b_empty = 1'b1;
            end else begin
              b_head--;
            end
          end
        end
      endcase
      if (r.status == dqsb_pkg::StsOverflow) overflows++;
      if (r.status == dqsb_pkg::StsUnderflow) underflows++;
      op_count[op]++;
      owed.push_back(r);
    endfunction

    // Compare one output transfer with the oldest owed result.
    function void check_response(logic [1:0] status, logic [31:0] word);
      result_t want;
      if (owed.size() == 0) begin
        failures++;
        if (failures <= ReportLimit)
          $display("unexpected result: status %0d word %h", status, word);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (status !== want.status || word !== want.word) begin
        failures++;
        if (failures <= ReportLimit)
          $display("mismatch on result %0d: status %0d word %h, wanted status %0d word %h",
                   checked, status, word, want.status, want.word);
      end
    endfunction
  endclass

  QueuePairScoreboard board;

  // Idle length per transfer; calm runs give back-to-back stretches.
  function automatic int draw_gap(inout bit calm, inout int run);
    if (run == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run = $urandom_range(10, 60);
    end
    run--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [1:0] pick_op(traffic_e mode);
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 7) begin
      case (mode)
        FillA:     op = dqsb_pkg::OpInsA;
        FillB:     op = dqsb_pkg::OpInsB;
        FillBoth:  op = $urandom_range(0, 1) ? dqsb_pkg::OpInsB : dqsb_pkg::OpInsA;
        DrainBoth: op = $urandom_range(0, 1) ? dqsb_pkg::OpRemB : dqsb_pkg::OpRemA;
        default: ;
      endcase
    end
    return op;
  endfunction

  // Present one item after an idle gap and hold it until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [31:0] value, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold off the sender until every owed result has come back.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (board.owed.size() != 0);
  endtask

  // Sample both handshakes on the edge; inputs first so the mirror leads the outputs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o)
        board.note_request(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        board.check_response(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  initial begin : receiver
    int gap, run;
    bit calm;
    calm = 1'b0;
    run = 0;
    m_axis_tready_i <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      gap = draw_gap(calm, run);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle = 0;
      else
        idle++;
    end
    $display("watchdog: no transfer for %0d cycles", IdleLimit);
    $display("testbench: errors");
    $finish;
  end

  initial begin : stimulus
    traffic_e    mode;
    int          mode_left, run;
    bit          calm;
    logic [1:0]  op;
    logic [31:0] value;
    board = new();
    rst_ni <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i <= '0;
    s_axis_tuser_i <= dqsb_pkg::OpInsA;
    calm = 1'b0;
    run = 0;
    mode = MixAll;
    mode_left = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Removals from empty queues, one entry each way with extreme words.
    send_item(dqsb_pkg::OpRemA, 32'hFFFF_FFFF, draw_gap(calm, run));
    send_item(dqsb_pkg::OpRemB, 32'h0000_0000, draw_gap(calm, run));
    send_item(dqsb_pkg::OpInsA, 32'h7FFF_FFFF, draw_gap(calm, run));
    send_item(dqsb_pkg::OpInsB, 32'h8000_0000, draw_gap(calm, run));
    // Each removal empties its queue and rewinds the pointers.
    send_item(dqsb_pkg::OpRemA, 32'h0000_0000, draw_gap(calm, run));
    send_item(dqsb_pkg::OpRemB, 32'hFFFF_FFFF, draw_gap(calm, run));
    // Fill the array from both ends until the queues meet, then push past it.
    for (int k = 0; k < Depth / 2; k++) begin
      send_item(dqsb_pkg::OpInsA, FillWords[k % 4], draw_gap(calm, run));
      send_item(dqsb_pkg::OpInsB, ~FillWords[k % 4], draw_gap(calm, run));
    end
    send_item(dqsb_pkg::OpInsA, 32'h1234_5678, draw_gap(calm, run));
    send_item(dqsb_pkg::OpInsB, 32'h8765_4321, draw_gap(calm, run));
    wait_drained();

    while (items_sent < NumItems) begin
      if (mode_left == 0) begin
        mode = traffic_e'($urandom_range(0, 4));
        mode_left = $urandom_range(15, 60);
      end
      mode_left--;
      op = pick_op(mode);
      value = ($urandom_range(0, 7) == 0) ? EdgeWords[$urandom_range(0, 3)] : $urandom();
      send_item(op, value, draw_gap(calm, run));
      if (items_sent % 500 == 0) wait_drained();
    end
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d transfers: %0d insert A, %0d insert B, %0d remove A, %0d remove B",
             items_sent, board.op_count[dqsb_pkg::OpInsA], board.op_count[dqsb_pkg::OpInsB],
             board.op_count[dqsb_pkg::OpRemA], board.op_count[dqsb_pkg::OpRemB]);
    $display("%0d overflows, %0d underflows, %0d results compared, %0d failures",
             board.overflows, board.underflows, board.checked, board.failures);
    if (board.failures == 0 && board.owed.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== dual_queue_shared_buffer.f =====
+incdir+hdl
hdl/dqsb_pkg.sv
hdl/dqsb_ctrl.sv
hdl/dqsb_dp.sv
hdl/dual_queue_shared_buffer.sv
sim/testbench.sv
